[rtl/b2a_pkg.sv]
// ============================================================================
// b2a_pkg : shared types and constants for the binary to ASCII decimal core
// Word formats, the flow word passed along the digit cells, and powers of ten.
// ============================================================================
package b2a_pkg;

    localparam int NUM_DIGITS = 7;
    localparam int REM_W      = 24;

    localparam logic [7:0]       ASCII_ZERO  = 8'd48;
    localparam logic [7:0]       ASCII_MINUS = 8'h2D;
    localparam logic [7:0]       ASCII_PLUS  = 8'h2B;
    localparam logic [7:0]       ASCII_NUL   = 8'h00;
    localparam logic [31:0]      SAT_U32     = 32'd9999999;
    localparam logic [REM_W-1:0] NEG16_BASE  = 24'h010000;

    typedef enum logic [1:0]
    {
        KIND_S16 = 2'd0,
        KIND_U16 = 2'd1,
        KIND_U32 = 2'd2
    } kind_t;

    typedef struct packed
    {
        logic [1:0]  kind;
        logic [31:0] value;
    } in_word_t;

    typedef struct packed
    {
        logic [7:0] code;
        logic       last;
    } out_word_t;

    typedef struct packed
    {
        kind_t                           kind;
        logic                            neg;
        logic [REM_W-1:0]                rem;
        logic [NUM_DIGITS-1:0][3:0]      digits;
    } flow_t;

    function automatic logic [REM_W-1:0] pow10(input int idx);
        logic [REM_W-1:0] p;
        case (idx)
            0:       p = 24'd1000000;
            1:       p = 24'd100000;
            2:       p = 24'd10000;
            3:       p = 24'd1000;
            4:       p = 24'd100;
            5:       p = 24'd10;
            default: p = 24'd1;
        endcase
        return p;
    endfunction

endpackage

[rtl/binary_to_ascii_decimal_core.sv]
// ============================================================================
// binary_to_ascii_decimal_core : fixed-width ASCII decimal printer
// Converts a 16-bit signed, 16-bit unsigned or saturated 32-bit number into
// a run of ASCII characters closed by a zero byte.
// ============================================================================
//
//  channel   direction  payload                      accepted when
//  in        in         in_word_t  {kind, value}     in_valid && in_ready
//  out       out        out_word_t {code, last}      out_valid && out_ready
//
//  A number gives 7, 6, 8 or 1 output words (signed 16, unsigned 16,
//  unsigned 32, undefined kind), sent by the serialiser one word per
//  cycle while out_ready is high; input words advance as it takes each number.
//  With the chain free, the first character is presented once the number
//  has passed the prep stage, which loads on the accepting edge, then the
//  seven digit cells, then the serialiser load.
//  Reset clears the valid bits and the serialiser position only; no clearing pass.
//  The cell chain advances only when the serialiser takes a number, and
//  in_ready follows it, so a stall on out freezes the whole chain.
//
module binary_to_ascii_decimal_core
    import b2a_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_word_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_data
);

    logic                  en;
    logic                  prep_valid_reg;
    flow_t                 prep_reg;
    flow_t                 prep_next;
    logic [15:0]           low;
    logic [NUM_DIGITS:0]   valid_chain;
    flow_t                 flow_chain [NUM_DIGITS+1];

    always_comb
    begin
        low              = in_data.value[15:0];
        prep_next.kind   = kind_t'(in_data.kind);
        prep_next.neg    = 1'b0;
        prep_next.rem    = '0;
        prep_next.digits = '0;
        case (in_data.kind)
            KIND_S16:
            begin
                prep_next.neg = low[15];
                // form the magnitude in 24 bits so the most negative value fits
                prep_next.rem = low[15] ? (NEG16_BASE - {8'd0, low}) : {8'd0, low};
            end
            KIND_U16:
            begin
                prep_next.rem = {8'd0, low};
            end
            KIND_U32:
            begin
                prep_next.rem = (in_data.value > SAT_U32) ? SAT_U32[REM_W-1:0]
                                                          : in_data.value[REM_W-1:0];
            end
            default:
            begin
                prep_next.rem = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            prep_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prep_reg <= prep_next;
        end
    end

    assign in_ready       = en;
    assign valid_chain[0] = prep_valid_reg;
    assign flow_chain[0]  = prep_reg;

    for (genvar i = 0; i < NUM_DIGITS; i++)
    begin : g_cell
        b2a_digit_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .pow       (pow10(i)),
            .in_valid  (valid_chain[i]),
            .in_flow   (flow_chain[i]),
            .out_valid (valid_chain[i+1]),
            .out_flow  (flow_chain[i+1])
        );
    end

    b2a_serializer u_ser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (valid_chain[NUM_DIGITS]),
        .in_flow    (flow_chain[NUM_DIGITS]),
        .load_ready (en),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

`ifndef ASSERT_OFF
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_data.last |=> out_valid)
        else $error("character run broke off before its zero byte");

    a_last_is_nul: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.last |-> out_data.code == ASCII_NUL)
        else $error("terminating word is not a zero byte");

    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("chain stalled with the serialiser empty");
`endif

endmodule

[rtl/b2a_digit_cell.sv]
// ============================================================================
// b2a_digit_cell : one decimal digit stage
// Extracts the digit for one power of ten and hands the remainder onward.
// ============================================================================
module b2a_digit_cell
    import b2a_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic [REM_W-1:0] pow,
    input  logic             in_valid,
    input  flow_t            in_flow,
    output logic             out_valid,
    output flow_t            out_flow
);

    logic             valid_reg;
    flow_t            flow_reg;
    flow_t            flow_next;
    logic [8:0]       ge;
    logic [3:0]       digit;
    logic [REM_W-1:0] sub;

    always_comb
    begin
        // remainder is below ten times pow, so the compares are a thermometer
        for (int m = 1; m < 10; m++)
        begin
            ge[m-1] = (in_flow.rem >= REM_W'(pow * REM_W'(m)));
        end
        digit = 4'($countones(ge));
        sub   = REM_W'(pow * {20'd0, digit});

        flow_next        = in_flow;
        flow_next.rem    = in_flow.rem - sub;
        flow_next.digits = {in_flow.digits[NUM_DIGITS-2:0], digit};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            flow_reg <= flow_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_flow  = flow_reg;

endmodule

[rtl/b2a_serializer.sv]
// ============================================================================
// b2a_serializer : character output stage
// Holds one number, emits its characters one word per cycle unless stalled.
// ============================================================================
module b2a_serializer
    import b2a_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  flow_t     in_flow,
    output logic      load_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_data
);

    logic                        busy_reg;
    logic [2:0]                  pos_reg;
    logic [2:0]                  pos_next;
    kind_t                       kind_reg;
    logic                        neg_reg;
    logic [NUM_DIGITS-1:0][3:0]  digits_reg;
    logic                        fire;
    logic [2:0]                  didx;
    logic                        is_digit;
    out_word_t                   word;

    always_comb
    begin
        didx     = 3'd0;
        is_digit = 1'b0;
        word     = '{code: ASCII_NUL, last: 1'b0};
        case (kind_reg)
            KIND_S16:
            begin
                if (pos_reg == 3'd0)
                begin
                    word.code = neg_reg ? ASCII_MINUS : ASCII_PLUS;
                end
                else if (pos_reg <= 3'd5)
                begin
                    is_digit = 1'b1;
                    didx     = 3'd5 - pos_reg;
                end
                else
                begin
                    word.last = 1'b1;
                end
            end
            KIND_U16:
            begin
                if (pos_reg <= 3'd4)
                begin
                    is_digit = 1'b1;
                    didx     = 3'd4 - pos_reg;
                end
                else
                begin
                    word.last = 1'b1;
                end
            end
            KIND_U32:
            begin
                if (pos_reg <= 3'd6)
                begin
                    is_digit = 1'b1;
                    didx     = 3'd6 - pos_reg;
                end
                else
                begin
                    word.last = 1'b1;
                end
            end
            default:
            begin
                word.last = 1'b1;
            end
        endcase
        if (is_digit)
        begin
            word.code = ASCII_ZERO + {4'd0, digits_reg[didx]};
        end
    end

    assign out_valid  = busy_reg;
    assign out_data   = word;
    assign fire       = busy_reg && out_ready;
    // take the next number when idle or as the terminating byte leaves
    assign load_ready = !busy_reg || (fire && word.last);
    assign pos_next   = pos_reg + 3'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pos_reg  <= 3'd0;
        end
        else if (load_ready)
        begin
            busy_reg <= in_valid;
            pos_reg  <= 3'd0;
        end
        else if (fire)
        begin
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_ready)
        begin
            kind_reg   <= in_flow.kind;
            neg_reg    <= in_flow.neg;
            digits_reg <= in_flow.digits;
        end
    end

endmodule

[bench/binary_to_ascii_decimal_core_checker.sv]
`timescale 1ns / 100ps
// ============================================================================
// binary_to_ascii_decimal_core_checker : character stream scoreboard
// Watches both channels of the core, works out the ASCII run that each
// accepted number should produce and compares every output word against it.
// ============================================================================
module binary_to_ascii_decimal_core_checker
    import b2a_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_ready,
    input  in_word_t  in_data,
    input  logic      out_valid,
    input  logic      out_ready,
    input  out_word_t out_data,
    output int        mismatches,
    output int        outstanding
);

    out_word_t expected_chars[$];

    function automatic void push_char(logic [7:0] code, logic last);
        out_word_t w;
        w.code = code;
        w.last = last;
        expected_chars.push_back(w);
    endfunction

    // Emit a fixed number of decimal digits, most significant first.
    function automatic void push_digits(logic [31:0] mag, int ndigits);
        logic [31:0] scale;
        logic [31:0] rest;
        logic [31:0] digit;
        scale = 32'd1;
        repeat (ndigits - 1) scale = scale * 32'd10;
        rest = mag;
        for (int i = 0; i < ndigits; i++)
        begin
            digit = rest / scale;
            rest  = rest % scale;
            push_char(ASCII_ZERO + digit[7:0], 1'b0);
            scale = scale / 32'd10;
        end
    endfunction

    function automatic void predict_chars(in_word_t w);
        logic [15:0] low;
        logic [31:0] mag;
        low = w.value[15:0];
        case (w.kind)
            KIND_S16:
            begin
                // take the magnitude in 32 bits so that -32768 does not wrap
                if (low[15])
                begin
                    mag = 32'h0001_0000 - {16'h0000, low};
                    push_char(ASCII_MINUS, 1'b0);
                end
                else
                begin
                    mag = {16'h0000, low};
                    push_char(ASCII_PLUS, 1'b0);
                end
                push_digits(mag, 5);
            end
            KIND_U16:
            begin
                push_digits({16'h0000, low}, 5);
            end
            KIND_U32:
            begin
                push_digits((w.value > SAT_U32) ? SAT_U32 : w.value, 7);
            end
            default:
            begin
            end
        endcase
        push_char(ASCII_NUL, 1'b1);
    endfunction

    always @(posedge clk)
    begin
        out_word_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                predict_chars(in_data);
            if (out_valid && out_ready)
            begin
                if (expected_chars.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: unexpected word code=%02h last=%0b",
                                 $realtime, out_data.code, out_data.last);
                    mismatches = mismatches + 1;
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (out_data.code !== want.code || out_data.last !== want.last)
                    begin
                        if (mismatches < 10)
                            $display({"%0t: word mismatch code exp %02h got %02h,",
                                      " last exp %0b got %0b"},
                                     $realtime, want.code, out_data.code,
                                     want.last, out_data.last);
                        mismatches = mismatches + 1;
                    end
                end
            end
            outstanding <= expected_chars.size();
        end
    end

endmodule

[bench/binary_to_ascii_decimal_core_tb.sv]
`timescale 1ns / 100ps
// ============================================================================
// binary_to_ascii_decimal_core_tb : top level bench for the decimal printer
// Drives directed corner numbers and then random numbers of every format,
// with random gaps on the input and random stalls on the output; a separate
// checker scores the character stream.
// ============================================================================
module binary_to_ascii_decimal_core_tb
    import b2a_pkg::*;
;

    localparam logic [1:0] KIND_UNDEF   = 2'd3;
    localparam int         RANDOM_ITEMS = 210;
    localparam int         IDLE_LIMIT   = 1000;
    localparam int         DRAIN_CYCLES = 20;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_word_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_word_t out_data;
    int        mismatches;
    int        outstanding;
    int        idle_cycles;
    bit        send_burst;
    bit        take_burst;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    binary_to_ascii_decimal_core u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    binary_to_ascii_decimal_core_checker u_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Count cycles with no word moving on either channel.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("FAIL");
        $finish;
    end

    // Switch now and then between back-to-back and randomly spaced words.
    function automatic int draw_wait(ref bit burst);
        if ($urandom_range(0, 15) == 0)
            burst = !burst;
        return burst ? 0 : int'($urandom_range(0, 19));
    endfunction

    // Receiver: stall a random number of cycles before taking each word.
    initial
    begin
        int stall;
        out_ready  = 1'b0;
        take_burst = 1'b0;
        forever
        begin
            stall = draw_wait(take_burst);
            @(negedge clk);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // Hold each word until accepted; lower valid only when a gap follows.
    task automatic send_word(logic [1:0] kind, logic [31:0] value);
        int gap;
        gap = draw_wait(send_burst);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid      <= 1'b1;
        in_data.kind  <= kind;
        in_data.value <= value;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
    endtask

    task automatic send_random_word();
        logic [1:0]  kind;
        logic [31:0] value;
        int          pick;
        pick  = $urandom_range(0, 15);
        value = $urandom;
        if (pick == 0)
            kind = KIND_UNDEF;
        else if (pick <= 5)
            kind = KIND_S16;
        else if (pick <= 10)
            kind = KIND_U16;
        else
            kind = KIND_U32;
        if (kind == KIND_U32)
        begin
            // keep most 32-bit numbers printable, with some near saturation
            case ($urandom_range(0, 3))
                0:       value = $urandom_range(0, SAT_U32);
                1:       value = $urandom_range(0, 99999);
                2:       value = $urandom_range(SAT_U32 - 8, SAT_U32 + 8);
                default: value = $urandom;
            endcase
        end
        send_word(kind, value);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        send_burst    = 1'b0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // signed 16-bit corners, including the most negative value
        send_word(KIND_S16, 32'd0);
        send_word(KIND_S16, 32'd1);
        send_word(KIND_S16, 32'h0000_7FFF);
        send_word(KIND_S16, 32'h0000_8000);
        send_word(KIND_S16, 32'h0000_FFFF);
        send_word(KIND_S16, 32'hFFFF_7FFF);
        send_word(KIND_S16, 32'h1234_8000);
        // unsigned 16-bit, upper half of value must be dropped
        send_word(KIND_U16, 32'd0);
        send_word(KIND_U16, 32'h0000_FFFF);
        send_word(KIND_U16, 32'hABCD_0000);
        send_word(KIND_U16, 32'h5A5A_FFFF);
        send_word(KIND_U16, 32'd12345);
        // unsigned 32-bit around the saturation point
        send_word(KIND_U32, 32'd0);
        send_word(KIND_U32, SAT_U32);
        send_word(KIND_U32, SAT_U32 + 32'd1);
        send_word(KIND_U32, 32'hFFFF_FFFF);
        send_word(KIND_U32, 32'd1234567);
        send_word(KIND_U32, 32'h8000_0000);
        // undefined format gives the terminator alone
        send_word(KIND_UNDEF, 32'd0);
        send_word(KIND_UNDEF, 32'hFFFF_FFFF);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS / 2)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                wait_drained();
            end
            send_random_word();
        end
        @(negedge clk);
        in_valid <= 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[files.f]
rtl/b2a_pkg.sv
rtl/b2a_digit_cell.sv
rtl/b2a_serializer.sv
rtl/binary_to_ascii_decimal_core.sv
bench/binary_to_ascii_decimal_core_checker.sv
bench/binary_to_ascii_decimal_core_tb.sv
